// ----- hdl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the stereo FIR decimator modules: the
// payload structs of both channels, the register indexes of the
// configuration port and the control struct of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int DECIM_W    = 8;
  localparam int TAPS_W     = 7;
  localparam int CIDX_W     = 6;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CFG_DECIM      = 2'd0,
    CFG_TAP_COUNT  = 2'd1,
    CFG_COEF_INDEX = 2'd2,
    CFG_COEF_VALUE = 2'd3
  } sfd_cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } sfd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } sfd_out_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } sfd_mac_ctl_t;

endpackage

// ----- hdl/sfd_ram.sv -----
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/sfd_mac.sv -----
// ----------------------------------------------------------------------------
// sfd_mac
// Stereo multiply-accumulate unit. Each step multiplies both channel
// samples by one coefficient, keeps the upper word of each product and adds
// it to a wrapping 32-bit accumulator.
// ----------------------------------------------------------------------------
module sfd_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sfd_pkg::sfd_mac_ctl_t               ctl,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] a_l,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] a_r,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] b,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] acc_l,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] acc_r,
  output logic                                busy
);

  import sfd_pkg::*;

  logic signed [2*SAMPLE_W-1:0] prod_l;
  logic signed [2*SAMPLE_W-1:0] prod_r;
  logic [SAMPLE_W-1:0] ph_l_r, ph_r_r;
  logic                pv_r;
  logic [SAMPLE_W-1:0] acc_l_r, acc_r_r;
  logic [SAMPLE_W-1:0] acc_l_nxt, acc_r_nxt;

  assign prod_l = a_l * b;
  assign prod_r = a_r * b;

  always_comb begin
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    if (ctl.clr) begin
      acc_l_nxt = '0;
      acc_r_nxt = '0;
    end else if (pv_r) begin
      acc_l_nxt = acc_l_r + ph_l_r;
      acc_r_nxt = acc_r_r + ph_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      ph_l_r  <= '0;
      ph_r_r  <= '0;
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else begin
      pv_r    <= ctl.vld;
      ph_l_r  <= prod_l[2*SAMPLE_W-1:SAMPLE_W];
      ph_r_r  <= prod_r[2*SAMPLE_W-1:SAMPLE_W];
      acc_l_r <= acc_l_nxt;
      acc_r_r <= acc_r_nxt;
    end
  end

  assign acc_l = acc_l_r;
  assign acc_r = acc_r_r;
  assign busy  = pv_r;

endmodule

// ----- hdl/stereo_fir_decimator_q31.sv -----
// ----------------------------------------------------------------------------
// stereo_fir_decimator_q31
// Two-channel FIR decimator for Q1.31 samples and coefficients.
// ----------------------------------------------------------------------------
// Each input transfer carries one left/right sample pair, which is written
// into a shared ring-buffer history memory. The first input of every group
// of decimation_factor inputs starts a filter pass; the others are only
// stored and produce no output. A pass runs one tap per cycle through a
// shared stereo multiply-accumulate unit, reading the history and the
// coefficient memory at one address each, so its length is set by the
// number of taps in use (tap_count, limited to MAX_TAPS). Each tap passes
// through the memory read registers, the product registers and the
// accumulator, then into the output register; the input side stalls from the
// input transfer until the result has been loaded into the output register.
// A finished result waits in the output register while the receiver stalls;
// the pass that follows it cannot complete until it has been taken.
// Configuration writes take effect at the next clock edge. The user must make
// them only while no transfer is in flight; the block does not enforce this.
// Reset clears the history fill count, the coefficient valid flags and the
// decimation phase, so history and coefficients read as zero until written;
// no clearing pass is needed and the block is ready in the cycle after
// reset.
// ----------------------------------------------------------------------------
module stereo_fir_decimator_q31 #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sfd_pkg::sfd_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sfd_pkg::sfd_out_t                    out_data,
  input  logic                                 cfg_we,
  input  sfd_pkg::sfd_cfg_reg_t                cfg_idx,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import sfd_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t              state_r, state_nxt;
  logic [DECIM_W-1:0]  decim_r, decim_nxt;
  logic [TAPS_W-1:0]   taps_r, taps_nxt;
  logic [CIDX_W-1:0]   cidx_r, cidx_nxt;
  logic [MAX_TAPS-1:0] cvalid_r, cvalid_nxt;
  logic [DECIM_W-1:0]  phase_r, phase_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       haddr_r, haddr_nxt;
  logic [AW-1:0]       caddr_r, caddr_nxt;
  logic [CW-1:0]       step_r, step_nxt;
  logic                v1_r, v1_nxt;
  logic                sok_r, sok_nxt;
  logic                cok_r, cok_nxt;
  logic                out_valid_r, out_valid_nxt;
  sfd_out_t            out_data_r, out_data_nxt;

  logic                in_xfer;
  logic                out_xfer;
  logic                coef_we;
  logic [DECIM_W-1:0]  factor;
  logic [DECIM_W:0]    phase_inc;
  logic [CW-1:0]       taps_eff;
  logic                pipe_empty;
  sfd_in_t             hist_rd;
  logic [SAMPLE_W-1:0] coef_rd;
  logic signed [SAMPLE_W-1:0] a_l, a_r, b;
  logic signed [SAMPLE_W-1:0] acc_l, acc_r;
  logic                mac_busy;
  sfd_mac_ctl_t        mac_ctl;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && (state_r == ST_IDLE);
  assign out_xfer   = out_valid_r && !out_stall;
  assign coef_we    = cfg_we && (cfg_idx == CFG_COEF_VALUE) &&
                      (32'(cidx_r) < 32'(MAX_TAPS));
  assign factor     = (decim_r == '0) ? DECIM_W'(1) : decim_r;
  assign phase_inc  = {1'b0, phase_r} + (DECIM_W + 1)'(1);
  assign taps_eff   = (32'(taps_r) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(taps_r);
  assign pipe_empty = !v1_r && !mac_busy;

  assign mac_ctl.clr = in_xfer;
  assign mac_ctl.vld = v1_r;

  assign a_l = sok_r ? hist_rd.left_sample  : '0;
  assign a_r = sok_r ? hist_rd.right_sample : '0;
  assign b   = cok_r ? coef_rd : '0;

  sfd_ram #(
    .WIDTH ($bits(sfd_in_t)),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp_r),
    .wdata (in_data),
    .raddr (haddr_r),
    .rdata (hist_rd)
  );

  sfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(cidx_r)),
    .wdata (cfg_wdata),
    .raddr (caddr_r),
    .rdata (coef_rd)
  );

  sfd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_l   (a_l),
    .a_r   (a_r),
    .b     (b),
    .acc_l (acc_l),
    .acc_r (acc_r),
    .busy  (mac_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    decim_nxt     = decim_r;
    taps_nxt      = taps_r;
    cidx_nxt      = cidx_r;
    cvalid_nxt    = cvalid_r;
    phase_nxt     = phase_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    haddr_nxt     = haddr_r;
    caddr_nxt     = caddr_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    v1_nxt        = (state_r == ST_RUN);
    sok_nxt       = (step_r < fill_r);
    cok_nxt       = cvalid_r[caddr_r];

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DECIM:      decim_nxt = cfg_wdata[DECIM_W-1:0];
        CFG_TAP_COUNT:  taps_nxt  = cfg_wdata[TAPS_W-1:0];
        CFG_COEF_INDEX: cidx_nxt  = cfg_wdata[CIDX_W-1:0];
        CFG_COEF_VALUE: begin
          if (coef_we) begin
            cvalid_nxt[AW'(cidx_r)] = 1'b1;
          end
        end
      endcase
    end

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          wp_nxt   = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
          fill_nxt = (fill_r == CW'(MAX_TAPS)) ? fill_r : fill_r + CW'(1);
          phase_nxt = (phase_inc >= {1'b0, factor}) ? '0 : phase_inc[DECIM_W-1:0];
          if (phase_r == '0) begin
            haddr_nxt = wp_r;
            caddr_nxt = AW'(taps_eff - CW'(1));
            step_nxt  = '0;
            state_nxt = (taps_eff == '0) ? ST_DRAIN : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        haddr_nxt = (haddr_r == '0) ? AW'(MAX_TAPS - 1) : haddr_r - AW'(1);
        caddr_nxt = caddr_r - AW'(1);
        step_nxt  = step_r + CW'(1);
        if (CW'(step_r + CW'(1)) == taps_eff) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && (!out_valid_r || !out_stall)) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.left_out  = {acc_l[SAMPLE_W-2:0], 1'b0};
          out_data_nxt.right_out = {acc_r[SAMPLE_W-2:0], 1'b0};
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      decim_r     <= DECIM_W'(1);
      taps_r      <= TAPS_W'(1);
      cidx_r      <= '0;
      cvalid_r    <= '0;
      phase_r     <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      haddr_r     <= '0;
      caddr_r     <= '0;
      step_r      <= '0;
      v1_r        <= 1'b0;
      sok_r       <= 1'b0;
      cok_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      decim_r     <= decim_nxt;
      taps_r      <= taps_nxt;
      cidx_r      <= cidx_nxt;
      cvalid_r    <= cvalid_nxt;
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      haddr_r     <= haddr_nxt;
      caddr_r     <= caddr_nxt;
      step_r      <= step_nxt;
      v1_r        <= v1_nxt;
      sok_r       <= sok_nxt;
      cok_r       <= cok_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/sfd_checker.sv -----
// ----------------------------------------------------------------------------
// sfd_checker
// Watches the input, result and configuration ports of the stereo FIR
// decimator. It keeps its own copy of both delay lines, the coefficient
// memory, the decimation phase and the registers. From these it works out
// the expected output pair for every input transfer that starts a group.
// Each result transfer is compared field by field with the oldest
// expectation. The first ten mismatches are reported and all are counted.
// ----------------------------------------------------------------------------
module sfd_checker #(
  parameter int MAX_TAPS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  sfd_pkg::sfd_in_t      in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  sfd_pkg::sfd_out_t     out_data,
  input  logic                  cfg_we,
  input  sfd_pkg::sfd_cfg_reg_t cfg_idx,
  input  logic [31:0]           cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  import sfd_pkg::*;

  logic [31:0] left_hist  [MAX_TAPS];
  logic [31:0] right_hist [MAX_TAPS];
  logic [31:0] coef_mem   [MAX_TAPS];
  logic [7:0]  phase;
  logic [7:0]  decim;
  logic [6:0]  tap_count;
  logic [5:0]  coef_sel;
  sfd_out_t    expected_pairs [$];
  int          mismatches;

  function automatic logic [31:0] filter_window(input logic [31:0] line [MAX_TAPS],
                                                input int taps);
    logic [31:0] acc;
    longint      prod;
    int          base;
    acc  = '0;
    base = MAX_TAPS - taps;
    for (int k = 0; k < taps; k++) begin
      prod = longint'($signed(line[base + k])) * longint'($signed(coef_mem[k]));
      acc  = acc + prod[63:32];
    end
    return {acc[30:0], 1'b0};
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  task automatic take_pair(input sfd_in_t d);
    sfd_out_t e;
    int       factor;
    int       taps;
    int       next_phase;
    factor = (decim == 8'd0) ? 1 : int'(decim);
    taps   = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
    for (int k = 0; k < MAX_TAPS - 1; k++) begin
      left_hist[k]  = left_hist[k + 1];
      right_hist[k] = right_hist[k + 1];
    end
    left_hist[MAX_TAPS - 1]  = d.left_sample;
    right_hist[MAX_TAPS - 1] = d.right_sample;
    if (phase == 8'd0) begin
      e.left_out  = filter_window(left_hist, taps);
      e.right_out = filter_window(right_hist, taps);
      expected_pairs.push_back(e);
    end
    next_phase = int'(phase) + 1;
    phase      = (next_phase >= factor) ? 8'd0 : 8'(next_phase);
  endtask

  always @(posedge clk) begin : monitor
    sfd_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        left_hist[k]  = '0;
        right_hist[k] = '0;
        coef_mem[k]   = '0;
      end
      phase      = '0;
      decim      = 8'd1;
      tap_count  = 7'd1;
      coef_sel   = '0;
      mismatches = 0;
      expected_pairs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DECIM:      decim     = cfg_wdata[7:0];
          CFG_TAP_COUNT:  tap_count = cfg_wdata[6:0];
          CFG_COEF_INDEX: coef_sel  = cfg_wdata[5:0];
          CFG_COEF_VALUE: coef_mem[coef_sel] = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result transfer with no expectation waiting, got %h",
                     $time, out_data);
          end
        end else begin
          want = expected_pairs.pop_front();
          compare_field("left_out", want.left_out, out_data.left_out);
          compare_field("right_out", want.right_out, out_data.right_out);
        end
      end
      if (in_valid && !in_stall) begin
        take_pair(in_data);
      end
    end
    pending    <= expected_pairs.size();
    fail_count <= mismatches;
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the stereo FIR decimator with a short directed sequence of corner
// samples and register settings, then with phases of random sample pairs
// under random decimation factors, tap counts and coefficients. Both sides
// idle at random; once the receiver holds off long enough for the block to
// stall its input, and once the sender waits for every result mid-phase.
// Checking is done by sfd_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  import sfd_pkg::*;

  localparam int MAX_TAPS       = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  sfd_in_t      in_data;
  logic         out_valid;
  logic         out_stall;
  sfd_out_t     out_data;
  logic         cfg_we;
  sfd_cfg_reg_t cfg_idx;
  logic [31:0]  cfg_wdata;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  bit rx_hold_req  = 1'b0;
  bit calm         = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  stereo_fir_decimator_q31 #(
    .MAX_TAPS(MAX_TAPS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  sfd_checker #(
    .MAX_TAPS(MAX_TAPS)
  ) pair_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .fail_count(fail_count),
    .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pair(input logic [31:0] left, input logic [31:0] right);
    int gap;
    in_data  <= {left, right};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input sfd_cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_coef(input logic [5:0] idx, input logic [31:0] value);
    write_reg(CFG_COEF_INDEX, {26'($urandom()), idx});
    write_reg(CFG_COEF_VALUE, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_random();
    int         r;
    logic [7:0] factor;
    logic [6:0] taps;
    r = $urandom_range(0, 9);
    factor = (r == 0) ? 8'd0 : (r < 4) ? 8'd1 : 8'($urandom_range(2, 6));
    write_reg(CFG_DECIM, {24'($urandom()), factor});
    r = $urandom_range(0, 9);
    if (r == 0) taps = 7'd0;
    else if (r == 1) taps = 7'd64;
    else if (r == 2) taps = 7'($urandom_range(65, 127));
    else if (r < 6) taps = 7'($urandom_range(1, 6));
    else taps = 7'($urandom_range(7, 40));
    write_reg(CFG_TAP_COUNT, {25'($urandom()), taps});
    repeat ($urandom_range(2, 10)) set_coef(6'($urandom_range(0, 63)), rand_word());
  endtask

  initial begin : receiver
    int len;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall   <= 1'b0;
        rx_hold_req = 1'b0;
      end else begin
        len = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] corner_words [6];
    int          n;
    corner_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                     32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_DECIM;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one tap, every input produces, all coefficients zero.
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // A factor of zero behaves as one; coefficients at both ends of the range.
    write_reg(CFG_DECIM, 32'h0);
    write_reg(CFG_TAP_COUNT, 32'd4);
    set_coef(6'd0, 32'h7FFF_FFFF);
    set_coef(6'd1, 32'h8000_0000);
    set_coef(6'd2, 32'h4000_0000);
    set_coef(6'd3, 32'hFFFF_FFFF);
    set_coef(6'd63, 32'h1234_5678);
    for (int i = 0; i < 6; i++) begin
      send_pair(corner_words[i], corner_words[5 - i]);
    end
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    wait_drained();

    // No taps in use gives zero results.
    write_reg(CFG_TAP_COUNT, 32'd0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // A tap count above the maximum is limited; the group is left unfinished.
    write_reg(CFG_TAP_COUNT, 32'd127);
    write_reg(CFG_DECIM, 32'd3);
    repeat (7) send_pair(rand_word(), rand_word());
    wait_drained();

    // Lowering the factor mid-group ends the group with the next input.
    write_reg(CFG_DECIM, 32'd1);
    repeat (3) send_pair(rand_word(), rand_word());
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      configure_random();
      calm = (p == 2);
      if (p == 4) begin
        write_reg(CFG_DECIM, 32'd1);
        rx_hold_req = 1'b1;
      end
      n = $urandom_range(20, 40);
      for (int i = 0; i < n; i++) begin
        send_pair(rand_word(), rand_word());
        if (p == 6 && i == n / 2) wait_drained();
      end
      wait_drained();
    end
    calm = 1'b0;

    // Largest factor with every tap in use.
    write_reg(CFG_DECIM, 32'd255);
    write_reg(CFG_TAP_COUNT, 32'd64);
    repeat (100) send_pair(rand_word(), rand_word());
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
